// ===== hdl/ll1esc_pkg.sv =====
`default_nettype none

package ll1esc_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned Q_DEPTH         = 4;

  typedef enum logic [3:0] {
    SY_END = 4'd0,
    SY_E   = 4'd1,
    SY_A   = 4'd2,
    SY_T   = 4'd3,
    SY_B   = 4'd4,
    SY_F   = 4'd5,
    SY_ID  = 4'd6,
    SY_ADD = 4'd7,
    SY_MUL = 4'd8,
    SY_LP  = 4'd9,
    SY_RP  = 4'd10,
    SY_UNK = 4'd15
  } sym_e;

  typedef enum logic [1:0] {
    VD_RUN = 2'd0,
    VD_ACC = 2'd1,
    VD_REJ = 2'd2
  } verdict_e;

  typedef enum logic [2:0] {
    PS_INIT,
    PS_IDLE,
    PS_FETCH,
    PS_EVAL,
    PS_PUSH,
    PS_REPORT
  } psr_state_e;

  // one token on its way from the lexer to the parser
  typedef struct packed {
    logic line_end;
    sym_e sym;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // production body, bottom first: sym0 is pushed first, the last one ends on top
  typedef struct packed {
    logic       hit;
    logic [1:0] len;
    sym_e       sym0;
    sym_e       sym1;
    sym_e       sym2;
  } prod_t;

  function automatic prod_t prod_lookup(sym_e nt, sym_e tok);
    prod_t p;
    p.hit  = 1'b0;
    p.len  = 2'd0;
    p.sym0 = SY_END;
    p.sym1 = SY_END;
    p.sym2 = SY_END;
    unique case (nt)
      SY_E, SY_T: begin
        if (tok == SY_ID || tok == SY_LP) begin
          p.hit  = 1'b1;
          p.len  = 2'd2;
          p.sym0 = (nt == SY_E) ? SY_A : SY_B;
          p.sym1 = (nt == SY_E) ? SY_T : SY_F;
        end
      end
      SY_A: begin
        if (tok == SY_ADD) begin
          p.hit  = 1'b1;
          p.len  = 2'd3;
          p.sym0 = SY_A;
          p.sym1 = SY_T;
          p.sym2 = SY_ADD;
        end else if (tok == SY_RP || tok == SY_END) begin
          p.hit = 1'b1;
        end
      end
      SY_B: begin
        if (tok == SY_MUL) begin
          p.hit  = 1'b1;
          p.len  = 2'd3;
          p.sym0 = SY_B;
          p.sym1 = SY_F;
          p.sym2 = SY_MUL;
        end else if (tok == SY_ADD || tok == SY_RP || tok == SY_END) begin
          p.hit = 1'b1;
        end
      end
      SY_F: begin
        if (tok == SY_ID) begin
          p.hit  = 1'b1;
          p.len  = 2'd1;
          p.sym0 = SY_ID;
        end else if (tok == SY_LP) begin
          p.hit  = 1'b1;
          p.len  = 2'd3;
          p.sym0 = SY_RP;
          p.sym1 = SY_E;
          p.sym2 = SY_LP;
        end
      end
      default: begin
        p.hit = 1'b0;
      end
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ll1esc_lexer.sv =====
`default_nettype none

module ll1esc_lexer (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [7:0]           char_code_i,
  input  wire logic                 line_end_i,
  input  wire logic                 q_full_i,
  output ll1esc_pkg::q_push_t       push_o
);
  import ll1esc_pkg::*;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LP    = 8'h28;
  localparam logic [7:0] CH_RP    = 8'h29;
  localparam logic [7:0] CH_MUL   = 8'h2a;
  localparam logic [7:0] CH_ADD   = 8'h2b;
  localparam logic [7:0] CH_SUB   = 8'h2d;
  localparam logic [7:0] CH_DIV   = 8'h2f;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;

  logic in_id_q, in_id_d;
  logic accept;
  logic id_char;
  sym_e punct_sym;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign id_char    = (char_code_i >= CH_D0 && char_code_i <= CH_D9) ||
                      (char_code_i >= CH_LA && char_code_i <= CH_LZ);

  always_comb begin
    unique case (char_code_i) inside
      CH_LP:          punct_sym = SY_LP;
      CH_RP:          punct_sym = SY_RP;
      CH_ADD, CH_SUB: punct_sym = SY_ADD;
      CH_MUL, CH_DIV: punct_sym = SY_MUL;
      CH_HASH:        punct_sym = SY_END;
      default:        punct_sym = SY_UNK;
    endcase
  end

  always_comb begin
    in_id_d               = in_id_q;
    push_o.valid          = 1'b0;
    push_o.entry.line_end = 1'b0;
    push_o.entry.sym      = punct_sym;
    if (accept) begin
      if (line_end_i) begin
        in_id_d               = 1'b0;
        push_o.valid          = 1'b1;
        push_o.entry.line_end = 1'b1;
        push_o.entry.sym      = SY_END;
      end else if (id_char) begin
        // only the first character of a run makes a token
        in_id_d = 1'b1;
        if (!in_id_q) begin
          push_o.valid     = 1'b1;
          push_o.entry.sym = SY_ID;
        end
      end else begin
        in_id_d      = 1'b0;
        push_o.valid = (char_code_i != CH_SPACE);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_id_q <= 1'b0;
    end else begin
      in_id_q <= in_id_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ll1esc_fifo.sv =====
`default_nettype none

module ll1esc_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ll1esc_pkg::q_push_t  push_i,
  input  wire logic                 pop_i,
  output ll1esc_pkg::q_entry_t      head_o,
  output ll1esc_pkg::q_stat_t       stat_o
);
  import ll1esc_pkg::*;

  localparam int unsigned QAW = $clog2(Q_DEPTH);
  localparam int unsigned QCW = $clog2(Q_DEPTH + 1);

  q_entry_t         slot_q [Q_DEPTH];
  logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0]   level_q;
  logic             do_push, do_pop;

  assign stat_o.empty = (level_q == '0);
  assign stat_o.full  = (level_q == QCW'(Q_DEPTH));
  assign do_push      = push_i.valid && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QAW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QAW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
      end
      if (do_push && !do_pop) begin
        level_q <= level_q + QCW'(1);
      end else if (do_pop && !do_push) begin
        level_q <= level_q - QCW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ll1esc_parser.sv =====
`default_nettype none

module ll1esc_parser #(
  parameter int unsigned STACK_DEPTH = ll1esc_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ll1esc_pkg::q_entry_t head_i,
  input  wire ll1esc_pkg::q_stat_t  q_stat_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      accepted_o
);
  import ll1esc_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  psr_state_e     state_q, state_d;
  logic [CW-1:0]  count_q, count_d;
  sym_e           tok_q, tok_d;
  logic           le_q, le_d;
  verdict_e       verdict_q, verdict_d;
  sym_e           body_q [3];
  sym_e           body_d [3];
  logic [1:0]     len_q, len_d;
  logic [1:0]     idx_q, idx_d;
  logic           out_valid_q, out_valid_d;
  logic           accepted_q, accepted_d;

  // symbol stack; entry 0 is never written, and a read of it yields the end marker via rd_zero_q
  logic [3:0]     mem [STACK_DEPTH];
  logic [3:0]     rd_data_q;
  logic           rd_zero_q;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [3:0]     mem_wdata;

  sym_e           x_sym;
  logic           is_term, is_nt;
  prod_t          prod;
  logic [CW:0]    push_sum;
  logic           room;
  logic           eval_done;
  verdict_e       eval_verdict;
  logic [CW-1:0]  count_m1;
  logic           out_free;
  psr_state_e     fin_state;

  assign x_sym     = rd_zero_q ? SY_END : sym_e'(rd_data_q);
  assign is_term   = (x_sym >= SY_ID) && (x_sym <= SY_RP);
  assign is_nt     = (x_sym >= SY_E) && (x_sym <= SY_F);
  assign prod      = prod_lookup(x_sym, tok_q);
  assign push_sum  = {1'b0, count_q} + (CW+1)'(prod.len);
  assign room      = (push_sum <= (CW+1)'(STACK_DEPTH));
  assign eval_done = is_term || !is_nt || !prod.hit || !room;
  assign count_m1  = count_q - CW'(1);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign fin_state = le_q ? PS_REPORT : PS_IDLE;

  always_comb begin
    if (is_term) begin
      eval_verdict = (x_sym == tok_q) ? VD_RUN : VD_REJ;
    end else if (!is_nt) begin
      eval_verdict = (x_sym == SY_END && tok_q == SY_END) ? VD_ACC : VD_REJ;
    end else begin
      eval_verdict = VD_REJ;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      PS_INIT: state_d = PS_IDLE;
      PS_IDLE: begin
        if (!q_stat_i.empty) begin
          if (verdict_q == VD_RUN) begin
            state_d = PS_FETCH;
          end else if (head_i.line_end) begin
            state_d = PS_REPORT;
          end
        end
      end
      PS_FETCH: state_d = (count_q == '0) ? fin_state : PS_EVAL;
      PS_EVAL: begin
        if (eval_done) begin
          state_d = fin_state;
        end else if (prod.len < 2'd2) begin
          state_d = PS_FETCH;
        end else begin
          state_d = PS_PUSH;
        end
      end
      PS_PUSH:   state_d = (idx_q + 2'd1 == len_q) ? PS_FETCH : PS_PUSH;
      PS_REPORT: state_d = out_free ? PS_INIT : PS_REPORT;
      default:   state_d = PS_INIT;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d     = count_q;
    tok_d       = tok_q;
    le_d        = le_q;
    verdict_d   = verdict_q;
    body_d      = body_q;
    len_d       = len_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    accepted_d  = accepted_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = count_q[AW-1:0];
    mem_wdata   = 4'(SY_E);
    mem_re      = 1'b0;
    mem_raddr   = count_m1[AW-1:0];
    unique case (state_q)
      PS_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(1);
        mem_wdata = 4'(SY_E);
        count_d   = CW'(2);
        verdict_d = VD_RUN;
        le_d      = 1'b0;
      end
      PS_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          le_d  = head_i.line_end;
          tok_d = head_i.line_end ? SY_END : head_i.sym;
        end
      end
      PS_FETCH: begin
        if (count_q == '0) begin
          verdict_d = VD_REJ;
        end else begin
          count_d = count_m1;
          mem_re  = 1'b1;
        end
      end
      PS_EVAL: begin
        if (eval_done) begin
          verdict_d = eval_verdict;
        end else if (prod.len != 2'd0) begin
          mem_we    = 1'b1;
          mem_wdata = 4'(prod.sym0);
          count_d   = count_q + CW'(1);
          body_d[0] = prod.sym0;
          body_d[1] = prod.sym1;
          body_d[2] = prod.sym2;
          len_d     = prod.len;
          idx_d     = 2'd1;
        end
      end
      PS_PUSH: begin
        mem_we    = 1'b1;
        mem_wdata = 4'(body_q[idx_q]);
        count_d   = count_q + CW'(1);
        idx_d     = idx_q + 2'd1;
      end
      PS_REPORT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          accepted_d  = (verdict_q == VD_ACC);
        end
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
      rd_zero_q <= (mem_raddr == '0);
    end
    tok_q      <= tok_d;
    body_q     <= body_d;
    len_q      <= len_d;
    idx_q      <= idx_d;
    accepted_q <= accepted_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= PS_INIT;
      count_q     <= CW'(2);
      le_q        <= 1'b0;
      verdict_q   <= VD_RUN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      le_q        <= le_d;
      verdict_q   <= verdict_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign accepted_o  = accepted_q;

endmodule

`default_nettype wire

// ===== hdl/ll1_expression_syntax_checker.sv =====
// Channel  Handshake                 Payload
// in       in_valid_i / in_stall_o   char_code_i[7:0], line_end_i
// out      out_valid_o / out_stall_i accepted_o (one per line end)
//
// The lexer takes one character per cycle into a 4-entry token queue; it stalls only when full.
// For each token the parser dequeues it in PS_IDLE; each stack pop then reads the top in PS_FETCH
// and checks it in PS_EVAL, which writes the first symbol of an expansion, PS_PUSH the rest.
// A line end goes through the remaining pops; PS_REPORT then issues the verdict and PS_INIT
// reloads the stack base. Reset empties the queue and enters PS_INIT, which seeds the stack;
// output is registered, so a stalled verdict holds while characters keep filling the queue.
`default_nettype none

module ll1_expression_syntax_checker #(
  parameter int unsigned STACK_DEPTH = ll1esc_pkg::STACK_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] char_code_i,
  input  wire logic       line_end_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            accepted_o
);
  import ll1esc_pkg::*;

  q_push_t  push;
  q_entry_t head;
  q_stat_t  q_stat;
  logic     pop;

  ll1esc_lexer u_lexer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .line_end_i  (line_end_i),
    .q_full_i    (q_stat.full),
    .push_o      (push)
  );

  ll1esc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  ll1esc_parser #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .accepted_o  (accepted_o)
  );

  a_q_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.empty && q_stat.full))
    else $error("token queue both empty and full");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("parser dequeued from empty token queue");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> !q_stat.full)
    else $error("lexer emitted a token into a full queue");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> in_stall_o)
    else $error("input not stalled while token queue full");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ll1esc_pkg::*;

  localparam int unsigned DEPTH = STACK_DEPTH_DEF;

  typedef struct packed {
    logic [7:0] code;
    logic       le;
    logic       typed;
    logic       verdict;
  } stim_row_t;

  // Short lines first: the verdict is typed in where it is obvious, the rest
  // goes through the parser model.
  localparam stim_row_t DIRECTED [27] = '{
    '{8'h00, 1'b1, 1'b1, 1'b0},  // empty line is no expression
    '{"a",   1'b0, 1'b0, 1'b0},
    '{8'hff, 1'b1, 1'b1, 1'b1},  // single identifier, line-end byte ignored
    '{"(",   1'b0, 1'b0, 1'b0},
    '{"9",   1'b0, 1'b0, 1'b0},
    '{"z",   1'b0, 1'b0, 1'b0},
    '{"-",   1'b0, 1'b0, 1'b0},
    '{"b",   1'b0, 1'b0, 1'b0},
    '{")",   1'b0, 1'b0, 1'b0},
    '{"*",   1'b0, 1'b0, 1'b0},
    '{"c",   1'b0, 1'b0, 1'b0},
    '{"/",   1'b0, 1'b0, 1'b0},
    '{"d",   1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b1, 1'b0, 1'b0},
    '{"a",   1'b0, 1'b0, 1'b0},
    '{"+",   1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 1'b0},  // unknown byte
    '{8'h7f, 1'b1, 1'b1, 1'b0},
    '{"x",   1'b0, 1'b0, 1'b0},
    '{"#",   1'b0, 1'b0, 1'b0},  // end marker mid-line, rest is dropped
    '{")",   1'b0, 1'b0, 1'b0},
    '{8'h01, 1'b1, 1'b1, 1'b1},
    '{" ",   1'b0, 1'b0, 1'b0},
    '{"q",   1'b0, 1'b0, 1'b0},
    '{" ",   1'b0, 1'b0, 1'b0},  // space splits two identifiers
    '{"7",   1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b1, 1'b1, 1'b0}
  };

  localparam int unsigned RANDOM_ITEMS = 550;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] char_code_i = 8'h00;
  logic       line_end_i  = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       accepted_o;

  ll1_expression_syntax_checker #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .char_code_i(char_code_i),
    .line_end_i (line_end_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .accepted_o (accepted_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // parser model state
  sym_e        sym_stack [DEPTH];
  int unsigned sym_count;
  bit          in_ident;
  verdict_e    line_verdict;

  bit          pending_verdicts [$];
  logic [7:0]  line_buf [$];
  int          mismatches     = 0;
  int          verdicts_seen  = 0;
  int          accepts_seen   = 0;
  int          chars_sent     = 0;
  int          lines_sent     = 0;
  int          overflow_lines = 0;
  int          idle_odds      = 3;
  int          stall_odds     = 3;
  bit          quiet_tail     = 1'b0;

  function automatic void clear_line();
    foreach (sym_stack[k]) sym_stack[k] = SY_END;
    sym_stack[1] = SY_E;
    sym_count    = 2;
    in_ident     = 1'b0;
    line_verdict = VD_RUN;
  endfunction

  // Expand nonterminals on top of the stack until the token is matched, the line is accepted or it fails.
  function automatic void parse_token(sym_e tok);
    sym_e top;
    sym_e body [$];
    bit   hit;
    for (int guard = 0; guard < 4 * DEPTH + 16; guard++) begin
      if (sym_count == 0 || sym_count > DEPTH) begin
        line_verdict = VD_REJ;
        return;
      end
      sym_count--;
      top = sym_stack[sym_count];
      if (top >= SY_ID && top <= SY_RP) begin
        if (top != tok) line_verdict = VD_REJ;
        return;
      end
      if (top < SY_E || top > SY_F) begin
        line_verdict = (top == SY_END && tok == SY_END) ? VD_ACC : VD_REJ;
        return;
      end
      hit  = 1'b1;
      body = {};
      case (top)
        SY_E: begin
          if (tok == SY_ID || tok == SY_LP) body = '{SY_A, SY_T};
          else hit = 1'b0;
        end
        SY_T: begin
          if (tok == SY_ID || tok == SY_LP) body = '{SY_B, SY_F};
          else hit = 1'b0;
        end
        SY_A: begin
          if (tok == SY_ADD) body = '{SY_A, SY_T, SY_ADD};
          else hit = (tok == SY_RP || tok == SY_END);
        end
        SY_B: begin
          if (tok == SY_MUL) body = '{SY_B, SY_F, SY_MUL};
          else hit = (tok == SY_ADD || tok == SY_RP || tok == SY_END);
        end
        default: begin
          if (tok == SY_ID) body = '{SY_ID};
          else if (tok == SY_LP) body = '{SY_RP, SY_E, SY_LP};
          else hit = 1'b0;
        end
      endcase
      if (!hit || sym_count + body.size() > DEPTH) begin
        line_verdict = VD_REJ;
        return;
      end
      foreach (body[k]) begin
        sym_stack[sym_count] = body[k];
        sym_count++;
      end
    end
    line_verdict = VD_REJ;
  endfunction

  // Returns 1 when the transaction produces a verdict.
  function automatic bit parse_char(input logic [7:0] code, input logic le,
                                    output bit verdict_out);
    verdict_out = 1'b0;
    if (le) begin
      if (line_verdict == VD_RUN) parse_token(SY_END);
      verdict_out = (line_verdict == VD_ACC);
      clear_line();
      return 1'b1;
    end
    if (line_verdict != VD_RUN) return 1'b0;
    if ((code >= "0" && code <= "9") || (code >= "a" && code <= "z")) begin
      if (!in_ident) begin
        in_ident = 1'b1;
        parse_token(SY_ID);
      end
      return 1'b0;
    end
    in_ident = 1'b0;
    case (code)
      " ":      ;
      "(":      parse_token(SY_LP);
      ")":      parse_token(SY_RP);
      "+", "-": parse_token(SY_ADD);
      "*", "/": parse_token(SY_MUL);
      "#":      parse_token(SY_END);
      default:  parse_token(SY_UNK);
    endcase
    return 1'b0;
  endfunction

  function automatic logic [7:0] ident_char();
    int k;
    k = $urandom_range(0, 35);
    return (k < 10) ? 8'("0" + k) : 8'("a" + k - 10);
  endfunction

  function automatic void put_spaces();
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) line_buf.push_back(" ");
  endfunction

  // well-formed expression with random identifiers, operators and nesting
  function automatic void gen_expr(int lvl);
    int n_terms;
    int n_facts;
    n_terms = $urandom_range(1, (lvl > 2) ? 1 : 3);
    for (int t = 0; t < n_terms; t++) begin
      if (t > 0) line_buf.push_back($urandom_range(0, 1) ? "+" : "-");
      n_facts = $urandom_range(1, (lvl > 2) ? 1 : 3);
      for (int f = 0; f < n_facts; f++) begin
        if (f > 0) line_buf.push_back($urandom_range(0, 1) ? "*" : "/");
        put_spaces();
        if (lvl < 3 && $urandom_range(0, 3) == 0) begin
          line_buf.push_back("(");
          gen_expr(lvl + 1);
          line_buf.push_back(")");
        end else begin
          repeat ($urandom_range(1, 4)) line_buf.push_back(ident_char());
        end
        put_spaces();
      end
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns  MISMATCH  %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_char(input logic [7:0] code, input logic le,
                           input bit typed, input bit typed_verdict);
    bit produced;
    bit predicted;
    in_valid_i  <= 1'b1;
    char_code_i <= code;
    line_end_i  <= le;
    do @(posedge clk_i); while (in_stall_o);
    produced = parse_char(code, le, predicted);
    if (produced) pending_verdicts.push_back(typed ? typed_verdict : predicted);
    chars_sent++;
    if (idle_odds != 0 && !quiet_tail && $urandom_range(1, idle_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic drain_verdicts();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // output side: random stall bursts
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_odds != 0 && !quiet_tail && $urandom_range(1, stall_odds) == 1) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("verdict %b with no line end pending", accepted_o));
      end else begin
        if (accepted_o !== pending_verdicts[0])
          report_mismatch($sformatf("line %0d: accepted %b, expected %b",
                                    verdicts_seen, accepted_o, pending_verdicts[0]));
        void'(pending_verdicts.pop_front());
      end
      verdicts_seen++;
      if (accepted_o === 1'b1) accepts_seen++;
    end
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d verdicts outstanding", pending_verdicts.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int        target;
    int        r;
    int        nest;
    int        pos;
    int        odds_pick [3];
    string     punct;

    odds_pick = '{0, 2, 6};
    punct     = "()+*-/# ";
    clear_line();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i])
      send_char(DIRECTED[i].code, DIRECTED[i].le, DIRECTED[i].typed, DIRECTED[i].verdict);
    lines_sent += 6;
    drain_verdicts();

    target = chars_sent + RANDOM_ITEMS;
    while (chars_sent < target) begin
      quiet_tail = (chars_sent > target - 70);
      idle_odds  = odds_pick[$urandom_range(0, 2)];
      stall_odds = odds_pick[$urandom_range(0, 2)];
      line_buf   = {};
      r = $urandom_range(0, 99);
      if (r < 5) begin
        // deep nesting; past 20 levels the symbol stack overflows
        nest = $urandom_range(16, 24);
        if (nest > 20) overflow_lines++;
        repeat (nest) line_buf.push_back("(");
        line_buf.push_back(ident_char());
        repeat (nest) line_buf.push_back(")");
      end else if (r < 15) begin
        repeat ($urandom_range(0, 8)) line_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        gen_expr(0);
        if (r < 35) begin
          pos = $urandom_range(0, line_buf.size() - 1);
          case ($urandom_range(0, 2))
            0:       line_buf[pos] = 8'($urandom_range(0, 255));
            1:       line_buf.delete(pos);
            default: line_buf.insert(pos, punct[$urandom_range(0, 7)]);
          endcase
        end else if (r < 43) begin
          line_buf.push_back("#");
          repeat ($urandom_range(0, 4)) line_buf.push_back(8'($urandom_range(0, 255)));
        end
      end
      foreach (line_buf[k]) send_char(line_buf[k], 1'b0, 1'b0, 1'b0);
      send_char(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0);
      lines_sent++;
      if (!quiet_tail && $urandom_range(0, 9) == 0) drain_verdicts();
    end

    drain_verdicts();
    repeat (60) @(posedge clk_i);

    $display("%0d characters in %0d lines, %0d verdicts checked (%0d accepted)",
             chars_sent, lines_sent, verdicts_seen, accepts_seen);
    $display("%0d lines nested past the stack limit, %0d mismatches",
             overflow_lines, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
